FILE: sv/jpid_pkg.sv
// ----------------------------------------------------------------------------
// jpid_pkg
// Shared widths, fixed-point constants, register codes and stage payload
// types for the joint angle PID drive core.
// ----------------------------------------------------------------------------
package jpid_pkg;

    // Fixed-point setup
    localparam int ACCUM_WIDTH     = 32;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int ANGLE_FRAC_BITS = 4;

    // Field widths
    localparam int GAIN_W     = 16;
    localparam int ANGLE_W    = 14;
    localparam int TARGET_W   = 13;
    localparam int ERR_W      = 14;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Angle constants in 1/2^ANGLE_FRAC_BITS degree, full duty and unity gain
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int DUTY_FULL = 255;
    localparam int GAIN_ONE  = 1 << GAIN_FRAC_BITS;

    // Product and sum widths
    localparam int PE_W     = GAIN_W + ERR_W;
    localparam int PI_W     = GAIN_W + ACCUM_WIDTH;
    localparam int SUM_W    = PI_W + 2;
    localparam int SCALE_SH = GAIN_FRAC_BITS + ANGLE_FRAC_BITS;

    // Item request codes
    localparam logic REQ_TICK       = 1'b0;
    localparam logic REQ_SET_TARGET = 1'b1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = CFG_IDX_W'(0),
        CFG_GAIN_INTEG  = CFG_IDX_W'(1),
        CFG_GAIN_DERIV  = CFG_IDX_W'(2),
        CFG_DRIVE_LIMIT = CFG_IDX_W'(3)
    } t_cfg_index;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
        logic        [DUTY_W-1:0] limit;
    } t_gains;

    typedef struct packed {
        logic                          valid;
        logic                          held;
        logic signed [ERR_W-1:0]       err;
        logic signed [ACCUM_WIDTH-1:0] total;
        logic signed [ERR_W-1:0]       change;
    } t_err_item;

    typedef struct packed {
        logic                   valid;
        logic                   held;
        logic signed [PE_W-1:0] p_term;
        logic signed [PI_W-1:0] i_term;
        logic signed [PE_W-1:0] d_term;
    } t_prod_item;

    typedef struct packed {
        logic                    valid;
        logic                    held;
        logic signed [SUM_W-1:0] sum;
    } t_sum_item;

endpackage

FILE: sv/jpid_cfg_regs.sv
// ----------------------------------------------------------------------------
// jpid_cfg_regs
// Gain and drive limit register file, written through the config channel.
// ----------------------------------------------------------------------------
module jpid_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [jpid_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [jpid_pkg::CFG_DATA_W-1:0] i_wr_data,
    output jpid_pkg::t_gains                o_gains
);
    import jpid_pkg::*;

    t_gains r_gains;
    t_gains n_gains;

    always_comb begin
        n_gains = r_gains;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_GAIN_PROP:   n_gains.prop  = $signed(i_wr_data[GAIN_W-1:0]);
                CFG_GAIN_INTEG:  n_gains.integ = $signed(i_wr_data[GAIN_W-1:0]);
                CFG_GAIN_DERIV:  n_gains.deriv = $signed(i_wr_data[GAIN_W-1:0]);
                CFG_DRIVE_LIMIT: n_gains.limit = i_wr_data[DUTY_W-1:0];
                default:         n_gains = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= GAIN_W'(GAIN_ONE);
            r_gains.integ <= '0;
            r_gains.deriv <= '0;
            r_gains.limit <= DUTY_W'(DUTY_FULL);
        end else begin
            r_gains <= n_gains;
        end
    end

    assign o_gains = r_gains;

endmodule

FILE: sv/jpid_err_stage.sv
// ----------------------------------------------------------------------------
// jpid_err_stage
// Input register plus controller state: sample check, wrapped error,
// saturating error sum and error change.
// ----------------------------------------------------------------------------
module jpid_err_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_in_valid,
    input  logic                                 i_req_type,
    input  logic signed [jpid_pkg::ANGLE_W-1:0]  i_angle_sample,
    input  logic        [jpid_pkg::TARGET_W-1:0] i_target_angle,
    output jpid_pkg::t_err_item                  o_item
);
    import jpid_pkg::*;

    localparam logic signed [ERR_W-1:0] HALF_S = ERR_W'(HALF_TURN);
    localparam logic signed [ERR_W-1:0] FULL_S = ERR_W'(FULL_TURN);
    localparam logic [TARGET_W-1:0]     FULL_U = TARGET_W'(FULL_TURN);

    // Input register
    logic                       r_in_valid;
    logic                       r_req_type;
    logic signed [ANGLE_W-1:0]  r_angle;
    logic        [TARGET_W-1:0] r_target;

    // Controller state
    logic        [TARGET_W-1:0]    r_target_hold, n_target_hold;
    logic        [TARGET_W-1:0]    r_good_angle, n_good_angle;
    logic signed [ERR_W-1:0]       r_prev_error, n_prev_error;
    logic signed [ACCUM_WIDTH-1:0] r_error_total, n_error_total;

    t_err_item r_item, n_item;

    logic                          sample_ok;
    logic        [TARGET_W-1:0]    use_angle;
    logic signed [ERR_W-1:0]       raw_err;
    logic signed [ERR_W-1:0]       wrap_err;
    logic signed [ACCUM_WIDTH:0]   total_x;
    logic signed [ACCUM_WIDTH-1:0] total_sat;

    always_comb begin
        sample_ok = !r_angle[ANGLE_W-1] && (r_angle <= FULL_S);
        use_angle = sample_ok ? r_angle[TARGET_W-1:0] : r_good_angle;
        raw_err   = $signed({1'b0, r_target_hold}) - $signed({1'b0, use_angle});
        if (raw_err > HALF_S) begin
            wrap_err = raw_err - FULL_S;
        end else if (raw_err < -HALF_S) begin
            wrap_err = raw_err + FULL_S;
        end else begin
            wrap_err = raw_err;
        end
        total_x = {r_error_total[ACCUM_WIDTH-1], r_error_total}
                + {{(ACCUM_WIDTH+1-ERR_W){wrap_err[ERR_W-1]}}, wrap_err};
        // Saturate on overflow toward the sign of the true sum
        if (total_x[ACCUM_WIDTH] != total_x[ACCUM_WIDTH-1]) begin
            total_sat = {total_x[ACCUM_WIDTH], {(ACCUM_WIDTH-1){!total_x[ACCUM_WIDTH]}}};
        end else begin
            total_sat = total_x[ACCUM_WIDTH-1:0];
        end
    end

    always_comb begin
        n_target_hold = r_target_hold;
        n_good_angle  = r_good_angle;
        n_prev_error  = r_prev_error;
        n_error_total = r_error_total;
        n_item        = r_item;
        if (i_adv) begin
            n_item.valid  = 1'b0;
            n_item.held   = !sample_ok;
            n_item.err    = wrap_err;
            n_item.total  = total_sat;
            n_item.change = wrap_err - r_prev_error;
            if (r_in_valid && (r_req_type == REQ_SET_TARGET)) begin
                n_target_hold = (r_target > FULL_U) ? FULL_U : r_target;
                n_prev_error  = '0;
                n_error_total = '0;
            end else if (r_in_valid) begin
                n_item.valid  = 1'b1;
                n_good_angle  = use_angle;
                n_prev_error  = wrap_err;
                n_error_total = total_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_target_hold <= '0;
            r_good_angle  <= '0;
            r_prev_error  <= '0;
            r_error_total <= '0;
            r_item.valid  <= 1'b0;
        end else begin
            if (i_adv) begin
                r_in_valid <= i_in_valid;
            end
            r_target_hold <= n_target_hold;
            r_good_angle  <= n_good_angle;
            r_prev_error  <= n_prev_error;
            r_error_total <= n_error_total;
            r_item.valid  <= n_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req_type <= i_req_type;
            r_angle    <= i_angle_sample;
            r_target   <= i_target_angle;
        end
        r_item.held   <= n_item.held;
        r_item.err    <= n_item.err;
        r_item.total  <= n_item.total;
        r_item.change <= n_item.change;
    end

    assign o_item = r_item;

endmodule

FILE: sv/jpid_mac.sv
// ----------------------------------------------------------------------------
// jpid_mac
// Two-stage multiply and add: registered gain products, then their sum.
// ----------------------------------------------------------------------------
module jpid_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  jpid_pkg::t_gains     i_gains,
    input  jpid_pkg::t_err_item  i_item,
    output jpid_pkg::t_sum_item  o_item
);
    import jpid_pkg::*;

    t_prod_item r_prod, n_prod;
    t_sum_item  r_sum, n_sum;

    always_comb begin
        n_prod.valid  = i_item.valid;
        n_prod.held   = i_item.held;
        n_prod.p_term = PE_W'($signed(i_gains.prop) * $signed(i_item.err));
        n_prod.i_term = PI_W'($signed(i_gains.integ) * $signed(i_item.total));
        n_prod.d_term = PE_W'($signed(i_gains.deriv) * $signed(i_item.change));

        n_sum.valid = r_prod.valid;
        n_sum.held  = r_prod.held;
        n_sum.sum   = {{(SUM_W-PE_W){r_prod.p_term[PE_W-1]}}, r_prod.p_term}
                    + {{(SUM_W-PI_W){r_prod.i_term[PI_W-1]}}, r_prod.i_term}
                    + {{(SUM_W-PE_W){r_prod.d_term[PE_W-1]}}, r_prod.d_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
            r_sum.valid  <= 1'b0;
        end else if (i_adv) begin
            r_prod.valid <= n_prod.valid;
            r_sum.valid  <= n_sum.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod.held   <= n_prod.held;
            r_prod.p_term <= n_prod.p_term;
            r_prod.i_term <= n_prod.i_term;
            r_prod.d_term <= n_prod.d_term;
            r_sum.held    <= n_sum.held;
            r_sum.sum     <= n_sum.sum;
        end
    end

    assign o_item = r_sum;

endmodule

FILE: sv/jpid_drive_out.sv
// ----------------------------------------------------------------------------
// jpid_drive_out
// Scale down toward zero, clamp to the drive limit, split into magnitude and
// direction, and hold the result until it is taken.
// ----------------------------------------------------------------------------
module jpid_drive_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [jpid_pkg::DUTY_W-1:0]  i_limit,
    input  jpid_pkg::t_sum_item          i_item,
    output logic                         o_valid,
    output logic [jpid_pkg::DUTY_W-1:0]  o_pwm_duty,
    output logic                         o_reverse,
    output logic                         o_sample_held
);
    import jpid_pkg::*;

    logic                r_valid;
    logic [DUTY_W-1:0]   r_duty, n_duty;
    logic                r_reverse, n_reverse;
    logic                r_held;

    logic                sum_neg;
    logic [SUM_W-1:0]    sum_abs;
    logic [SUM_W-1:0]    mag_raw;
    logic [SUM_W-1:0]    limit_x;

    always_comb begin
        // Truncation toward zero is a shift of the magnitude
        sum_neg   = i_item.sum[SUM_W-1];
        sum_abs   = sum_neg ? (SUM_W'(0) - SUM_W'(i_item.sum)) : SUM_W'(i_item.sum);
        mag_raw   = sum_abs >> SCALE_SH;
        limit_x   = SUM_W'(i_limit);
        n_duty    = (mag_raw > limit_x) ? i_limit : mag_raw[DUTY_W-1:0];
        n_reverse = sum_neg && (n_duty != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_duty    <= n_duty;
            r_reverse <= n_reverse;
            r_held    <= i_item.held;
        end
    end

    assign o_valid       = r_valid;
    assign o_pwm_duty    = r_duty;
    assign o_reverse     = r_reverse;
    assign o_sample_held = r_held;

endmodule

FILE: sv/joint_angle_pid_drive_core.sv
// ----------------------------------------------------------------------------
// joint_angle_pid_drive_core
// Discrete PID position controller for one motor joint: angle samples in,
// PWM duty magnitude and direction out.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready    | req_type, angle_sample, target
//  out      | output    | o_out_valid / i_out_ready  | pwm_duty, reverse, sample_held
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle while no result waits untaken. A tick's transfer loads the
//  input register; its result then passes the error stage, product, sum and
//  result registers. The error sum update is a single add and saturate in the
//  error stage, so ticks may follow each other with no gap. Set-target items
//  give no result. Reset (synchronous, active low) clears the controller state
//  and the gains to their defaults. The pipeline moves as a whole: when a
//  result waits untaken, every stage holds and o_in_ready drops.
//
module joint_angle_pid_drive_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic signed [jpid_pkg::ANGLE_W-1:0]  i_angle_sample,
    input  logic        [jpid_pkg::TARGET_W-1:0] i_target_angle,
    // result item
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic        [jpid_pkg::DUTY_W-1:0]   o_pwm_duty,
    output logic                                 o_reverse,
    output logic                                 o_sample_held,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [jpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [jpid_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jpid_pkg::*;

    t_gains    gains;
    t_err_item err_item;
    t_sum_item sum_item;
    logic      adv;

    // Advance every stage unless a finished result is still waiting
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    jpid_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_gains    (gains)
    );

    // Hold the sample, update target, last good angle, error and error sum
    jpid_err_stage u_err_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_in_valid     (i_in_valid),
        .i_req_type     (i_req_type),
        .i_angle_sample (i_angle_sample),
        .i_target_angle (i_target_angle),
        .o_item         (err_item)
    );

    // Form the three gain products, then the PID sum
    jpid_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_gains (gains),
        .i_item  (err_item),
        .o_item  (sum_item)
    );

    // Scale, clamp and drive the result register
    jpid_drive_out u_drive_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_limit       (gains.limit),
        .i_item        (sum_item),
        .o_valid       (o_out_valid),
        .o_pwm_duty    (o_pwm_duty),
        .o_reverse     (o_reverse),
        .o_sample_held (o_sample_held)
    );

endmodule
